[design/sab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pkg: shared types and constants of the scaled alpha blit unit
// Field widths, command and register codes, words passed between the parts.
// ----------------------------------------------------------------------------
package sab_pkg;

    // fixed geometry of the texture store and the screen
    localparam int TEX_DIM_MAX    = 64;
    localparam int SCREEN_DIM_MAX = 4096;
    localparam int STORE_DEPTH    = TEX_DIM_MAX * TEX_DIM_MAX;

    localparam int COORD_W = 12;
    localparam int SPAN_W  = 13;
    localparam int DIM_W   = 7;
    localparam int WORD_W  = 32;
    localparam int TADDR_W = 12;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 13;
    localparam int IDX_W   = (TEX_DIM_MAX > 1) ? $clog2(TEX_DIM_MAX) : 1;
    localparam int PROD_W  = COORD_W + IDX_W;
    localparam int DIVW    = SPAN_W + IDX_W;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_BLEND = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IW-1:0] {
        REG_WIN_SX = 3'd0,
        REG_WIN_SY = 3'd1,
        REG_WIN_EX = 3'd2,
        REG_WIN_EY = 3'd3,
        REG_SPAN_X = 3'd4,
        REG_SPAN_Y = 3'd5,
        REG_TEX_W  = 3'd6,
        REG_TEX_H  = 3'd7
    } t_reg;

    // input word
    typedef struct packed {
        logic                command;
        logic [TADDR_W-1:0]  texel_address;
        logic [WORD_W-1:0]   texel_argb;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [WORD_W-1:0]   dest_rgb;
    } t_item;

    // result word
    typedef struct packed {
        logic [WORD_W-1:0] out_color;
        logic              inside_res;
    } t_result;

    // classified work word, front to back
    typedef struct packed {
        t_cmd                cmd;
        logic                in_win;
        logic [COORD_W-1:0]  offx;
        logic [COORD_W-1:0]  offy;
        logic [TADDR_W-1:0]  addr;
        logic [WORD_W-1:0]   data;   // texel for a load, destination for a blend
    } t_work;

    // sanitized scale settings used by the back end
    typedef struct packed {
        logic [SPAN_W-1:0] spanx;
        logic [SPAN_W-1:0] spany;
        logic [IDX_W-1:0]  nm1x;
        logic [IDX_W-1:0]  nm1y;
    } t_geom;

endpackage

[design/sab_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module sab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/sab_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_queue: short work queue between front and back
// Four-entry FIFO of classified work words.
// ----------------------------------------------------------------------------
module sab_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sab_pkg::t_work i_word,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sab_pkg::t_work o_word
);
    import sab_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PW     = $clog2(QDEPTH);

    t_work           r_buf [QDEPTH];
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [PW:0]     r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill update
    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_word;
        end
    end

endmodule

[design/sab_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_front: configuration registers and input classification
// Holds the window and scale registers, tests each pixel against the window,
// forms its offsets and hands one work word per cycle to the queue while it is not full.
// ----------------------------------------------------------------------------
module sab_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sab_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [sab_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_push,
    input  sab_pkg::t_item              i_item,
    output logic                        o_full,
    output logic                        o_q_push,
    output sab_pkg::t_work              o_q_word,
    input  logic                        i_q_full,
    output sab_pkg::t_geom              o_geom
);
    import sab_pkg::*;

    localparam logic [COORD_W:0] SCR_LIM = (COORD_W+1)'(SCREEN_DIM_MAX);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(TEX_DIM_MAX);

    logic [COORD_W-1:0] r_wsx, r_wsy, r_wex, r_wey;
    logic [SPAN_W-1:0]  r_spx, r_spy;
    logic [DIM_W-1:0]   r_tw, r_th;
    logic               r_valid;
    t_work              r_work, n_work;
    logic               adv, in_x, in_y;
    logic [DIM_W-1:0]   nx, ny;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsx <= '0;
            r_wsy <= '0;
            r_wex <= '0;
            r_wey <= '0;
            r_spx <= SPAN_W'(1);
            r_spy <= SPAN_W'(1);
            r_tw  <= DIM_W'(1);
            r_th  <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_WIN_SX: r_wsx <= i_cfg_data[COORD_W-1:0];
                REG_WIN_SY: r_wsy <= i_cfg_data[COORD_W-1:0];
                REG_WIN_EX: r_wex <= i_cfg_data[COORD_W-1:0];
                REG_WIN_EY: r_wey <= i_cfg_data[COORD_W-1:0];
                REG_SPAN_X: r_spx <= i_cfg_data[SPAN_W-1:0];
                REG_SPAN_Y: r_spy <= i_cfg_data[SPAN_W-1:0];
                REG_TEX_W:  r_tw  <= i_cfg_data[DIM_W-1:0];
                REG_TEX_H:  r_th  <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // sanitized scale settings: zero span as one, texture size clamped
    always_comb begin
        nx = (r_tw == '0) ? DIM_W'(1) : ((r_tw > DIM_MAX) ? DIM_MAX : r_tw);
        ny = (r_th == '0) ? DIM_W'(1) : ((r_th > DIM_MAX) ? DIM_MAX : r_th);
        o_geom.spanx = (r_spx == '0) ? SPAN_W'(1) : r_spx;
        o_geom.spany = (r_spy == '0) ? SPAN_W'(1) : r_spy;
        o_geom.nm1x  = IDX_W'(nx - 1'b1);
        o_geom.nm1y  = IDX_W'(ny - 1'b1);
    end

    // window test and offsets
    always_comb begin
        in_x = (i_item.pixel_x >= r_wsx) && (i_item.pixel_x <= r_wex)
            && ({1'b0, i_item.pixel_x} < SCR_LIM);
        in_y = (i_item.pixel_y >= r_wsy) && (i_item.pixel_y <= r_wey)
            && ({1'b0, i_item.pixel_y} < SCR_LIM);
        n_work.cmd    = t_cmd'(i_item.command);
        n_work.in_win = in_x && in_y;
        n_work.offx   = i_item.pixel_x - r_wsx;
        n_work.offy   = i_item.pixel_y - r_wsy;
        n_work.addr   = i_item.texel_address;
        n_work.data   = (t_cmd'(i_item.command) == CMD_LOAD) ? i_item.texel_argb
                                                            : i_item.dest_rgb;
    end

    // holding stage ahead of the queue
    assign adv      = !r_valid || !i_q_full;
    assign o_full   = !adv;
    assign o_q_push = r_valid;
    assign o_q_word = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_work <= n_work;
        end
    end

endmodule

[design/sab_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_back: texel pick, store access and blend pipeline
// Scales the offsets, divides by the span one quotient bit per stage, forms
// the store address, writes loads and reads texels, blends, and holds the
// result word. The whole line advances together while the result is free.
// ----------------------------------------------------------------------------
module sab_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sab_pkg::t_geom   i_geom,
    input  logic             i_q_valid,
    input  sab_pkg::t_work   i_q_word,
    output logic             o_q_pop,
    input  logic             pop,
    output logic             empty,
    output sab_pkg::t_result o_result
);
    import sab_pkg::*;

    localparam int NST = IDX_W + 1;

    // exact divide by 255 for values below 65280
    function automatic logic [7:0] div255(input logic [16:0] v);
        logic [16:0] t;
        t = v + 17'd1 + (v >> 8);
        return t[15:8];
    endfunction

    logic adv;

    // scale stage
    logic               r_a_v;
    t_work              r_a_w;
    logic [PROD_W-1:0]  r_a_px, r_a_py;

    // divider line; entry 0 is the range check stage
    logic               r_dv_v   [NST];
    t_work              r_dv_w   [NST];
    logic [PROD_W-1:0]  r_dv_rx  [NST];
    logic [PROD_W-1:0]  r_dv_ry  [NST];
    logic [IDX_W-1:0]   r_dv_qx  [NST];
    logic [IDX_W-1:0]   r_dv_qy  [NST];
    logic               r_dv_ox  [NST];
    logic               r_dv_oy  [NST];
    logic [PROD_W-1:0]  n_dv_rx  [NST];
    logic [PROD_W-1:0]  n_dv_ry  [NST];
    logic [IDX_W-1:0]   n_dv_qx  [NST];
    logic [IDX_W-1:0]   n_dv_qy  [NST];

    // address stage
    logic               r_c_v;
    t_work              r_c_w;
    logic [TADDR_W-1:0] r_c_addr;
    logic [IDX_W-1:0]   tx, ty;
    logic [2*IDX_W:0]   addr_full;

    // store stage
    logic               r_m_v;
    t_work              r_m_w;
    logic [WORD_W-1:0]  texel;

    // blend stage
    logic               r_e_v;
    logic               r_e_in;
    logic               r_e_opq;
    logic [WORD_W-1:0]  r_e_tex, r_e_dst;
    logic [16:0]        r_e_sum [3];
    logic [7:0]         alpha;

    // result hold
    logic               r_o_v;
    t_result            r_o_res, n_o_res;

    assign adv     = !r_o_v || pop;
    assign o_q_pop = adv && i_q_valid;
    assign empty   = !r_o_v;
    assign o_result = r_o_res;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_c_v <= 1'b0;
            r_m_v <= 1'b0;
            r_e_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_q_valid;
            r_c_v <= r_dv_v[NST-1];
            r_m_v <= r_c_v;
            r_e_v <= r_m_v && (r_m_w.cmd == CMD_BLEND);
            r_o_v <= r_e_v;
        end
    end

    // offset times texture size minus one
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_w  <= i_q_word;
            r_a_px <= PROD_W'(i_q_word.offx) * PROD_W'(i_geom.nm1x);
            r_a_py <= PROD_W'(i_q_word.offy) * PROD_W'(i_geom.nm1y);
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    always_comb begin
        logic [DIVW-1:0] shx, shy;
        logic            gex, gey;
        n_dv_rx[0] = '0;
        n_dv_ry[0] = '0;
        n_dv_qx[0] = '0;
        n_dv_qy[0] = '0;
        for (int i = 1; i < NST; i++) begin
            shx = DIVW'(i_geom.spanx) << (IDX_W - i);
            shy = DIVW'(i_geom.spany) << (IDX_W - i);
            gex = DIVW'(r_dv_rx[i-1]) >= shx;
            gey = DIVW'(r_dv_ry[i-1]) >= shy;
            n_dv_rx[i] = gex ? PROD_W'(DIVW'(r_dv_rx[i-1]) - shx) : r_dv_rx[i-1];
            n_dv_ry[i] = gey ? PROD_W'(DIVW'(r_dv_ry[i-1]) - shy) : r_dv_ry[i-1];
            n_dv_qx[i] = r_dv_qx[i-1];
            n_dv_qy[i] = r_dv_qy[i-1];
            n_dv_qx[i][IDX_W - i] = gex;
            n_dv_qy[i][IDX_W - i] = gey;
        end
    end

    // divider valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_dv_v[i] <= 1'b0;
            end
        end else if (adv) begin
            r_dv_v[0] <= r_a_v;
            for (int i = 1; i < NST; i++) begin
                r_dv_v[i] <= r_dv_v[i-1];
            end
        end
    end

    // range check: quotient beyond the index width saturates anyway
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_w[0]  <= r_a_w;
            r_dv_rx[0] <= r_a_px;
            r_dv_ry[0] <= r_a_py;
            r_dv_qx[0] <= '0;
            r_dv_qy[0] <= '0;
            r_dv_ox[0] <= DIVW'(r_a_px) >= (DIVW'(i_geom.spanx) << IDX_W);
            r_dv_oy[0] <= DIVW'(r_a_py) >= (DIVW'(i_geom.spany) << IDX_W);
            for (int i = 1; i < NST; i++) begin
                r_dv_w[i]  <= r_dv_w[i-1];
                r_dv_rx[i] <= n_dv_rx[i];
                r_dv_ry[i] <= n_dv_ry[i];
                r_dv_qx[i] <= n_dv_qx[i];
                r_dv_qy[i] <= n_dv_qy[i];
                r_dv_ox[i] <= r_dv_ox[i-1];
                r_dv_oy[i] <= r_dv_oy[i-1];
            end
        end
    end

    // saturate to the last texel and form the store address
    always_comb begin
        tx = (r_dv_ox[NST-1] || (r_dv_qx[NST-1] > i_geom.nm1x))
            ? i_geom.nm1x : r_dv_qx[NST-1];
        ty = (r_dv_oy[NST-1] || (r_dv_qy[NST-1] > i_geom.nm1y))
            ? i_geom.nm1y : r_dv_qy[NST-1];
        addr_full = (2*IDX_W+1)'(ty) * (2*IDX_W+1)'({1'b0, i_geom.nm1x} + 1'b1)
                  + (2*IDX_W+1)'(tx);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_w    <= r_dv_w[NST-1];
            r_c_addr <= addr_full[TADDR_W-1:0];
        end
    end

    // texel store: loads write and blends read at the same point of the line
    sab_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (adv && r_c_v && (r_c_w.cmd == CMD_LOAD)),
        .i_waddr (r_c_w.addr),
        .i_wdata (r_c_w.data),
        .i_re    (adv),
        .i_raddr (r_c_addr),
        .o_rdata (texel)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_w <= r_c_w;
        end
    end

    // blend products per channel
    assign alpha = texel[31:24];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_in  <= r_m_w.in_win;
            r_e_opq <= (alpha == 8'hFF);
            r_e_tex <= texel;
            r_e_dst <= r_m_w.data;
            for (int c = 0; c < 3; c++) begin
                r_e_sum[c] <= 17'(r_m_w.data[8*c +: 8] * (8'hFF - alpha))
                            + 17'(texel[8*c +: 8] * alpha);
            end
        end
    end

    // final color
    always_comb begin
        n_o_res.inside_res = r_e_in;
        if (!r_e_in) begin
            n_o_res.out_color = r_e_dst;
        end else if (r_e_opq) begin
            n_o_res.out_color = r_e_tex;
        end else begin
            n_o_res.out_color = {8'h00, div255(r_e_sum[2]), div255(r_e_sum[1]),
                                 div255(r_e_sum[0])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_res <= n_o_res;
        end
    end

endmodule

[design/scaled_alpha_blit_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_alpha_blit_unit: nearest-neighbor scaled blit with alpha blend
// Input words go in through push/full; a load word writes one texel into the
// 4096-entry texture store, a blend word carries one destination pixel.
// Each blend word gives one result word on empty/pop; loads give none.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data at once;
// write it only while the unit is idle.
// Throughput: one word per clock while the result is free. Its path to empty
// runs through the quotient-bit-per-stage span divider (one stage per index
// bit), the registered store read and the blend stages.
// Reset clears the control state; the texture store holds no reset value and
// must be loaded before its texels are used.
// When pop is held low the result holds, the back pipeline stops, the
// four-entry work queue fills and then full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module scaled_alpha_blit_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sab_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [sab_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  sab_pkg::t_item              i_item,
    input  logic                        pop,
    output logic                        empty,
    output sab_pkg::t_result            o_result
);
    import sab_pkg::*;

    logic  q_push, q_full, q_valid, q_pop;
    t_work q_in, q_out;
    t_geom geom;

    // classification and configuration
    sab_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_q_push   (q_push),
        .o_q_word   (q_in),
        .i_q_full   (q_full),
        .o_geom     (geom)
    );

    // decoupling queue
    sab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_word  (q_out)
    );

    // execution pipeline
    sab_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_q_valid (q_valid),
        .i_q_word  (q_out),
        .o_q_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .o_result  (o_result)
    );

endmodule
